### rtl/dssm_pkg.sv
// shared types and constants for the dual stack shared memory block
`timescale 1ns / 1ps
`default_nettype none

package dssm_pkg;

	localparam int DEPTH  = 1024;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = 11;
	localparam int DATA_W = 32;

	localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(1024);

	localparam logic [1:0] CMD_PUSH = 2'd0;
	localparam logic [1:0] CMD_POP  = 2'd1;
	localparam logic [1:0] CMD_PEEK = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_OVERFLOW  = 2'd1;
	localparam logic [1:0] ST_UNDERFLOW = 2'd2;

	// one classified request on its way to the memory side
	typedef struct packed {
		logic              wr;
		logic              rd;
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] wdata;
		logic [1:0]        status;
		logic [CNT_W-1:0]  count_low;
		logic [CNT_W-1:0]  count_high;
	} op_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

endpackage

`default_nettype wire

### rtl/dssm_front.sv
// request classification, occupancy counts and capacity register
`timescale 1ns / 1ps
`default_nettype none

module dssm_front (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [1:0]                  cmd,
	input  wire logic                        stack_select,
	input  wire logic signed [31:0]          data_in,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [10:0]                 capacity_in_use,
	input  wire dssm_pkg::fifo_stat_t        fifo_stat,
	output logic                             op_push,
	output dssm_pkg::op_t                    op
);
	import dssm_pkg::*;

	logic [CNT_W-1:0] low_q, high_q, cap_q;
	logic [CNT_W-1:0] cap_eff, sel_cnt, new_low, new_high, addr_full;
	logic [CNT_W:0]   total;
	logic             accept, cfg_wr;

	assign in_ready  = !fifo_stat.full;
	assign cfg_ready = 1'b1;
	assign accept    = in_valid && in_ready;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign op_push   = accept;

	always_comb begin
		cap_eff   = (cap_q > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : cap_q;
		total     = {1'b0, low_q} + {1'b0, high_q};
		sel_cnt   = stack_select ? high_q : low_q;
		new_low   = low_q;
		new_high  = high_q;
		addr_full = '0;
		op.wr     = 1'b0;
		op.rd     = 1'b0;
		op.status = ST_OK;
		case (cmd)
			CMD_PUSH: begin
				if (total >= {1'b0, cap_eff}) begin
					op.status = ST_OVERFLOW;
				end else begin
					op.wr = 1'b1;
					if (stack_select) begin
						addr_full = cap_eff - CNT_W'(1) - high_q;
						new_high  = high_q + CNT_W'(1);
					end else begin
						addr_full = low_q;
						new_low   = low_q + CNT_W'(1);
					end
				end
			end
			CMD_POP, CMD_PEEK: begin
				if (sel_cnt == '0) begin
					op.status = ST_UNDERFLOW;
				end else begin
					op.rd = 1'b1;
					if (stack_select) begin
						addr_full = cap_eff - high_q;
						if (cmd == CMD_POP) new_high = high_q - CNT_W'(1);
					end else begin
						addr_full = low_q - CNT_W'(1);
						if (cmd == CMD_POP) new_low = low_q - CNT_W'(1);
					end
				end
			end
			default: begin
			end
		endcase
		op.addr       = addr_full[ADDR_W-1:0];
		op.wdata      = data_in;
		op.count_low  = new_low;
		op.count_high = new_high;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q  <= '0;
			high_q <= '0;
			cap_q  <= CAP_RESET;
		end else if (cfg_wr) begin
			// new layout: both stacks start empty
			cap_q  <= capacity_in_use;
			low_q  <= '0;
			high_q <= '0;
		end else if (accept) begin
			low_q  <= new_low;
			high_q <= new_high;
		end
	end

endmodule

`default_nettype wire

### rtl/dssm_fifo.sv
// two entry queue of classified requests
`timescale 1ns / 1ps
`default_nettype none

module dssm_fifo (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire dssm_pkg::op_t        push_op,
	input  wire logic                 pop,
	output dssm_pkg::op_t             head_op,
	output dssm_pkg::fifo_stat_t      stat
);
	import dssm_pkg::*;

	op_t        entry_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] fill_q;

	assign stat.full  = (fill_q == 2'd2);
	assign stat.empty = (fill_q == 2'd0);
	assign head_op    = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

`default_nettype wire

### rtl/dssm_back.sv
// shared memory access and result register
`timescale 1ns / 1ps
`default_nettype none

module dssm_back (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire dssm_pkg::op_t        head_op,
	input  wire dssm_pkg::fifo_stat_t fifo_stat,
	output logic                      fifo_pop,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic signed [31:0]        data_out,
	output logic [1:0]                status,
	output logic [10:0]               count_low,
	output logic [10:0]               count_high
);
	import dssm_pkg::*;

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rd_data_q;
	logic              valid_q, rd_q;
	logic [1:0]        status_q;
	logic [CNT_W-1:0]  count_low_q, count_high_q;

	// issue when a request waits and the result slot frees up
	assign fifo_pop = !fifo_stat.empty && (!valid_q || out_ready);

	always_ff @(posedge clk) begin
		if (fifo_pop && head_op.wr) mem[head_op.addr] <= head_op.wdata;
		if (fifo_pop && head_op.rd) rd_data_q <= mem[head_op.addr];
	end

	always_ff @(posedge clk) begin
		if (fifo_pop) begin
			rd_q         <= head_op.rd;
			status_q     <= head_op.status;
			count_low_q  <= head_op.count_low;
			count_high_q <= head_op.count_high;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (fifo_pop) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	assign out_valid  = valid_q;
	assign data_out   = rd_q ? $signed(rd_data_q) : '0;
	assign status     = status_q;
	assign count_low  = count_low_q;
	assign count_high = count_high_q;

endmodule

`default_nettype wire

### rtl/dual_stack_shared_memory_top.sv
// top level of the dual stack shared memory block
`timescale 1ns / 1ps
`default_nettype none

// two lifo stacks in one 1024 x 32 memory: the low stack grows up from entry 0,
// the high stack grows down from entry capacity-1 (capacity saturates at 1024).
// each request (push, pop, peek) returns exactly one result with the word read
// (zero for push and on error), a status (ok, overflow, underflow) and both
// occupancy counts after the request; a failed request changes nothing.
// the front classifies a request in the cycle it is accepted and updates the
// counts there, so requests can follow every cycle; a two entry queue feeds the
// memory side, which does one memory access per request and holds the result in
// an output register. throughput is one request per cycle while the result channel
// is not stalled; a request is first written into the queue, and the memory access
// loads the result register once the request leaves the queue. a capacity write
// empties both stacks and must only happen while no request is in flight; the
// cfg port is always ready. memory contents are not cleared at reset, only pushed
// entries are ever read.
module dual_stack_shared_memory_top (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// request channel
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         cmd,
	input  wire logic               stack_select,
	input  wire logic signed [31:0] data_in,
	// result channel
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [31:0]      data_out,
	output logic [1:0]              status,
	output logic [10:0]             count_low,
	output logic [10:0]             count_high,
	// capacity register write
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [10:0]        capacity_in_use
);
	import dssm_pkg::*;

	op_t        front_op, head_op;
	fifo_stat_t fifo_stat;
	logic       op_push, fifo_pop;

	// classification and count bookkeeping
	dssm_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.cmd             (cmd),
		.stack_select    (stack_select),
		.data_in         (data_in),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.capacity_in_use (capacity_in_use),
		.fifo_stat       (fifo_stat),
		.op_push         (op_push),
		.op              (front_op)
	);

	// decouples the front from output stalls
	dssm_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (op_push),
		.push_op (front_op),
		.pop     (fifo_pop),
		.head_op (head_op),
		.stat    (fifo_stat)
	);

	// memory access in request order keeps read after write correct
	dssm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_op    (head_op),
		.fifo_stat  (fifo_stat),
		.fifo_pop   (fifo_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.data_out   (data_out),
		.status     (status),
		.count_low  (count_low),
		.count_high (count_high)
	);

endmodule

`default_nettype wire

### rtl/dssm_checker.sv
// port level checks for the dual stack shared memory block
`timescale 1ns / 1ps
`default_nettype none

module dssm_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_ready,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire logic signed [31:0] data_out,
	input wire logic [1:0]         status,
	input wire logic [10:0]        count_low,
	input wire logic [10:0]        count_high
);
	import dssm_pkg::*;

	// result held while stalled
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(data_out) && $stable(status))
		else $error("result changed while stalled");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_OK || status == ST_OVERFLOW || status == ST_UNDERFLOW))
		else $error("bad status code");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> data_out == '0)
		else $error("nonzero data on error");

	a_occupancy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ({1'b0, count_low} + {1'b0, count_high}) <= 12'(DEPTH))
		else $error("occupancy beyond memory size");

	// handshake signals known once out of reset
	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown({in_valid, in_ready, out_valid}))
		else $error("unknown handshake signal");

endmodule

bind dual_stack_shared_memory_top dssm_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.data_out   (data_out),
	.status     (status),
	.count_low  (count_low),
	.count_high (count_high)
);

`default_nettype wire
